@@ hw/rtl/bmhq_pkg.sv @@
// Shared types and codes for the binary max-heap priority queue.
// No dependencies; imported by binary_max_heap_queue_core.
package bmhq_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned PayW   = 16;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 7;

  typedef enum logic {
    CMD_INSERT  = 1'b0,
    CMD_EXTRACT = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_UP_PLACE,
    ST_EX_ROOT,
    ST_EX_LAST,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic            cmd;
    logic [KeyW-1:0] item_key;
    logic [PayW-1:0] item_payload;
  } req_t;

  typedef struct packed {
    logic [KeyW-1:0]   out_key;
    logic [PayW-1:0]   out_payload;
    logic [StatW-1:0]  status;
    logic [CountW-1:0] count;
  } rsp_t;

endpackage

@@ hw/rtl/bmhq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module bmhq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/binary_max_heap_queue_core.sv @@
// Bounded binary max-heap priority queue: insert and extract-max of key/payload pairs.
// Depends on bmhq_pkg and bmhq_ram.
//
// One command is in flight at a time; every command yields exactly one response beat with
// the count after the command. Entries live in one RAM with a single read port, which sets
// the pace. An insert climbs at most log2(CAPACITY) levels; an extract descends at most
// log2(CAPACITY)-1 levels and reads the two children one after the other. Errors (insert
// when full, extract when empty) leave the heap unchanged. A response still held off by
// the receiver stalls the next command in its finish state. The next command is taken in
// the cycle after its response is presented, while that response may still wait.
module binary_max_heap_queue_core #(
  parameter int unsigned CAPACITY     = 64,
  parameter int unsigned KEY_BITS     = 16,
  parameter int unsigned PAYLOAD_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bmhq_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bmhq_pkg::rsp_t out_data_o
);
  import bmhq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = CW + 1;
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned EW = KEY_BITS + PAYLOAD_BITS;

  state_e                  state_q, state_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [PW-1:0]           hole_q, hole_d;
  logic [KEY_BITS-1:0]     x_key_q, x_key_d;
  logic [PAYLOAD_BITS-1:0] x_pay_q, x_pay_d;
  logic [EW-1:0]           lft_q, lft_d;
  logic [KEY_BITS-1:0]     res_key_q, res_key_d;
  logic [PAYLOAD_BITS-1:0] res_pay_q, res_pay_d;
  status_e                 status_q, status_d;
  logic                    out_valid_q, out_valid_d;
  rsp_t                    out_data_q, out_data_d;

  logic                    ram_we, ram_re;
  logic [AW-1:0]           ram_waddr, ram_raddr;
  logic [EW-1:0]           ram_wdata, ram_rdata;

  logic                    accept, is_insert, full, empty, out_free;
  logic [KEY_BITS-1:0]     rd_key, lft_key, pick_key;
  logic [PW-1:0]           cnt_ext, ins_pos, ins_par, par, lc, rc;
  logic                    lc_in, rc_in, up_gt, l_gt_now, l_gt_q, r_gt;
  logic [EW-1:0]           x_ent;

  bmhq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign is_insert   = (in_data_i.cmd == CMD_INSERT);
  assign full        = (cnt_q == CW'(CAPACITY));
  assign empty       = (cnt_q == '0);
  assign out_free    = !out_valid_q || out_ready_i;

  assign rd_key      = ram_rdata[EW-1 -: KEY_BITS];
  assign lft_key     = lft_q[EW-1 -: KEY_BITS];
  assign x_ent       = {x_key_q, x_pay_q};

  assign cnt_ext     = {1'b0, cnt_q};
  assign ins_pos     = cnt_ext + PW'(1);
  assign ins_par     = ins_pos >> 1;
  assign par         = hole_q >> 1;
  assign lc          = {hole_q[PW-2:0], 1'b0};
  assign rc          = {hole_q[PW-2:0], 1'b1};
  assign lc_in       = (lc <= cnt_ext);
  assign rc_in       = (rc <= cnt_ext);

  assign up_gt       = (x_key_q > rd_key);
  assign l_gt_now    = (rd_key > x_key_q);
  assign l_gt_q      = (lft_key > x_key_q);
  assign pick_key    = l_gt_q ? lft_key : x_key_q;
  assign r_gt        = (rd_key > pick_key);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (is_insert) begin
            state_d = (full || empty) ? ST_FIN : ST_UP_CMP;
          end else begin
            state_d = empty ? ST_FIN : ST_EX_ROOT;
          end
        end
      end
      ST_UP_CMP: begin
        if (up_gt) begin
          state_d = (par == PW'(1)) ? ST_UP_PLACE : ST_UP_CMP;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_UP_PLACE: state_d = ST_FIN;
      ST_EX_ROOT:  state_d = ST_EX_LAST;
      ST_EX_LAST:  state_d = (cnt_q == CW'(1)) ? ST_FIN : ST_DN_RDL;
      ST_DN_RDL:   state_d = lc_in ? ST_DN_RDR : ST_FIN;
      ST_DN_RDR: begin
        if (rc_in) begin
          state_d = ST_DN_CMP;
        end else begin
          state_d = l_gt_now ? ST_DN_RDL : ST_FIN;
        end
      end
      ST_DN_CMP:   state_d = (r_gt || l_gt_q) ? ST_DN_RDL : ST_FIN;
      ST_FIN:      state_d = out_free ? ST_IDLE : ST_FIN;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control; the moving entry is held in x_q, the hole is written last
  always_comb begin
    cnt_d       = cnt_q;
    hole_d      = hole_q;
    x_key_d     = x_key_q;
    x_pay_d     = x_pay_q;
    lft_d       = lft_q;
    res_key_d   = res_key_q;
    res_pay_d   = res_pay_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_key_d = '0;
          res_pay_d = '0;
          status_d  = STAT_OK;
          x_key_d   = KEY_BITS'(in_data_i.item_key);
          x_pay_d   = PAYLOAD_BITS'(in_data_i.item_payload);
          if (is_insert) begin
            if (full) begin
              status_d = STAT_FULL;
            end else begin
              cnt_d  = cnt_q + CW'(1);
              hole_d = ins_pos;
              if (empty) begin
                ram_we    = 1'b1;
                ram_wdata = {KEY_BITS'(in_data_i.item_key),
                             PAYLOAD_BITS'(in_data_i.item_payload)};
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(ins_par - PW'(1));
              end
            end
          end else if (empty) begin
            status_d = STAT_EMPTY;
          end else begin
            ram_re = 1'b1;
          end
        end
      end
      ST_UP_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(hole_q - PW'(1));
        if (up_gt) begin
          ram_wdata = ram_rdata;
          hole_d    = par;
          if (par != PW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = AW'((par >> 1) - PW'(1));
          end
        end else begin
          ram_wdata = x_ent;
        end
      end
      ST_UP_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(hole_q - PW'(1));
        ram_wdata = x_ent;
      end
      ST_EX_ROOT: begin
        res_key_d = rd_key;
        res_pay_d = ram_rdata[PAYLOAD_BITS-1:0];
        ram_re    = 1'b1;
        ram_raddr = AW'(cnt_q - CW'(1));
      end
      ST_EX_LAST: begin
        x_key_d = rd_key;
        x_pay_d = ram_rdata[PAYLOAD_BITS-1:0];
        cnt_d   = cnt_q - CW'(1);
        hole_d  = PW'(1);
      end
      ST_DN_RDL: begin
        if (lc_in) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(lc - PW'(1));
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(hole_q - PW'(1));
          ram_wdata = x_ent;
        end
      end
      ST_DN_RDR: begin
        lft_d = ram_rdata;
        if (rc_in) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(rc - PW'(1));
        end else begin
          ram_we    = 1'b1;
          ram_waddr = AW'(hole_q - PW'(1));
          if (l_gt_now) begin
            ram_wdata = ram_rdata;
            hole_d    = lc;
          end else begin
            ram_wdata = x_ent;
          end
        end
      end
      ST_DN_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(hole_q - PW'(1));
        if (r_gt) begin
          ram_wdata = ram_rdata;
          hole_d    = rc;
        end else if (l_gt_q) begin
          ram_wdata = lft_q;
          hole_d    = lc;
        end else begin
          ram_wdata = x_ent;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{
            out_key:     KeyW'(res_key_q),
            out_payload: PayW'(res_pay_q),
            status:      status_q,
            count:       CountW'(cnt_q)
          };
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q     <= hole_d;
    x_key_q    <= x_key_d;
    x_pay_q    <= x_pay_d;
    lft_q      <= lft_d;
    res_key_q  <= res_key_d;
    res_pay_q  <= res_pay_d;
    status_q   <= status_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("heap count above capacity");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write to the same entry in one cycle");

  a_rsp_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("response beat raised outside the finish state");

  a_busy_no_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("command taken while the previous one is still in progress");

endmodule

@@ dv/tb.sv @@
// Testbench for binary_max_heap_queue_core: a directed table, then random insert/extract beats.
// Depends on bmhq_pkg and the core RTL; a local heap model predicts the beats the table does not fix.
`timescale 1ns / 100ps

module tb;
  import bmhq_pkg::*;

  localparam int unsigned HeapCap = 64;

  typedef struct {
    cmd_e            cmd;
    logic [KeyW-1:0] key;
    logic [PayW-1:0] pay;
    int unsigned     reps;
    bit              fixed;
    rsp_t            want;
  } dir_row_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  logic [KeyW-1:0] heap_keys [1:HeapCap];
  logic [PayW-1:0] heap_tags [1:HeapCap];
  int unsigned     heap_fill = 0;

  rsp_t        due_rsp_q[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rx_hold_req = 0;

  binary_max_heap_queue_core #(
    .CAPACITY    (HeapCap),
    .KEY_BITS    (KeyW),
    .PAYLOAD_BITS(PayW)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic void swap_entries(input int unsigned a, input int unsigned b);
    logic [KeyW-1:0] tk;
    logic [PayW-1:0] tp;
    tk = heap_keys[a];
    tp = heap_tags[a];
    heap_keys[a] = heap_keys[b];
    heap_tags[a] = heap_tags[b];
    heap_keys[b] = tk;
    heap_tags[b] = tp;
  endfunction

  function automatic rsp_t heap_apply(input req_t beat);
    rsp_t        r;
    int unsigned pos;
    int unsigned pick;
    r = '0;
    if (beat.cmd == CMD_INSERT) begin
      if (heap_fill >= HeapCap) begin
        r.status = STAT_FULL;
      end else begin
        heap_fill++;
        heap_keys[heap_fill] = beat.item_key;
        heap_tags[heap_fill] = beat.item_payload;
        pos = heap_fill;
        while (pos > 1 && heap_keys[pos] > heap_keys[pos / 2]) begin
          swap_entries(pos, pos / 2);
          pos = pos / 2;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.out_key     = heap_keys[1];
        r.out_payload = heap_tags[1];
        heap_keys[1]  = heap_keys[heap_fill];
        heap_tags[1]  = heap_tags[heap_fill];
        heap_fill--;
        pos = 1;
        forever begin
          pick = pos;
          if (2 * pos <= heap_fill && heap_keys[2 * pos] > heap_keys[pos]) pick = 2 * pos;
          if (2 * pos + 1 <= heap_fill && heap_keys[2 * pos + 1] > heap_keys[pick]) begin
            pick = 2 * pos + 1;
          end
          if (pick == pos) break;
          swap_entries(pos, pick);
          pos = pick;
        end
      end
    end
    r.count = heap_fill[CountW-1:0];
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic [KeyW-1:0] k, input logic [PayW-1:0] p,
                                  input status_e s, input logic [CountW-1:0] c);
    rsp_t r;
    r.out_key     = k;
    r.out_payload = p;
    r.status      = s;
    r.count       = c;
    return r;
  endfunction

  task automatic add_row(input cmd_e c, input logic [KeyW-1:0] k, input logic [PayW-1:0] p,
                         input int unsigned reps, input bit fixed, input rsp_t want);
    dir_row_t row;
    row.cmd   = c;
    row.key   = k;
    row.pay   = p;
    row.reps  = reps;
    row.fixed = fixed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // one beat on the command channel; the expectation is queued at acceptance
  task automatic drive_beat(input req_t beat, input bit fixed, input rsp_t fixed_rsp);
    rsp_t want;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk_i); while (!in_ready);
    want = heap_apply(beat);
    if (fixed) want = fixed_rsp;
    due_rsp_q.insert(due_rsp_q.size(), want);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    wait (due_rsp_q.size() == 0);
    @(posedge clk_i);
  endtask

  initial begin : rx_side
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req != 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (due_rsp_q.size() == 0) begin
        $error("response beat with nothing pending: %0h", out_data);
        mismatch_cnt++;
      end else begin
        want = due_rsp_q.pop_front();
        check_field("out_key", 32'(want.out_key), 32'(out_data.out_key));
        check_field("out_payload", 32'(want.out_payload), 32'(out_data.out_payload));
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("count", 32'(want.count), 32'(out_data.count));
      end
    end
  end

  initial begin : stim
    req_t        beat;
    dir_row_t    row;
    int unsigned seg_left;
    int unsigned ins_bias;
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab  = '{0, 75, 0, 37};
    stall_tab = '{0, 0, 75, 37};
    seg_left  = 0;
    ins_bias  = 50;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(CMD_EXTRACT, 16'h0000, 16'h0000, 1, 1, mk_rsp(16'h0, 16'h0, STAT_EMPTY, 7'd0));
    add_row(CMD_INSERT, 16'h0000, 16'h0000, 1, 1, mk_rsp(16'h0, 16'h0, STAT_OK, 7'd1));
    add_row(CMD_INSERT, 16'hFFFF, 16'hFFFF, 1, 1, mk_rsp(16'h0, 16'h0, STAT_OK, 7'd2));
    add_row(CMD_INSERT, 16'h8000, 16'h1234, 1, 0, '0);
    add_row(CMD_INSERT, 16'h8000, 16'h5678, 1, 0, '0);
    add_row(CMD_EXTRACT, 16'hFFFF, 16'hFFFF, 1, 1, mk_rsp(16'hFFFF, 16'hFFFF, STAT_OK, 7'd3));
    add_row(CMD_EXTRACT, 16'h0000, 16'h0000, 2, 0, '0);
    add_row(CMD_EXTRACT, 16'h0000, 16'h0000, 1, 1, mk_rsp(16'h0, 16'h0, STAT_OK, 7'd0));
    add_row(CMD_EXTRACT, 16'hFFFF, 16'hFFFF, 1, 1, mk_rsp(16'h0, 16'h0, STAT_EMPTY, 7'd0));
    // fill with equal keys: ties do not swap, and the heap model predicts which payload leaves the root
    add_row(CMD_INSERT, 16'h00FF, 16'hA000, HeapCap, 0, '0);
    add_row(CMD_INSERT, 16'hFFFF, 16'h5555, 1, 1, mk_rsp(16'h0, 16'h0, STAT_FULL, 7'd64));
    add_row(CMD_EXTRACT, 16'h0000, 16'h0000, HeapCap, 0, '0);
    add_row(CMD_EXTRACT, 16'h0000, 16'h0000, 1, 1, mk_rsp(16'h0, 16'h0, STAT_EMPTY, 7'd0));
    add_row(CMD_INSERT, 16'h5555, 16'hAAAA, 1, 1, mk_rsp(16'h0, 16'h0, STAT_OK, 7'd1));
    add_row(CMD_INSERT, 16'hAAAA, 16'h5555, 1, 1, mk_rsp(16'h0, 16'h0, STAT_OK, 7'd2));
    add_row(CMD_EXTRACT, 16'h0000, 16'h0000, 1, 1, mk_rsp(16'hAAAA, 16'h5555, STAT_OK, 7'd1));
    add_row(CMD_EXTRACT, 16'h0000, 16'h0000, 1, 1, mk_rsp(16'h5555, 16'hAAAA, STAT_OK, 7'd0));

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      for (int unsigned i = 0; i < row.reps; i++) begin
        beat.cmd          = row.cmd;
        beat.item_key     = row.key;
        beat.item_payload = row.pay + PayW'(i);
        drive_beat(beat, row.fixed, row.want);
      end
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      for (int n = 0; n < 315; n++) begin
        if (ph == 0 && n == 100) rx_hold_req = 400;
        if (seg_left == 0) begin
          seg_left = $urandom_range(120, 10);
          case ($urandom_range(2))
            0: ins_bias = 85;
            1: ins_bias = 15;
            default: ins_bias = 50;
          endcase
        end
        seg_left--;
        beat.cmd = ($urandom_range(99) < ins_bias) ? CMD_INSERT : CMD_EXTRACT;
        case ($urandom_range(3))
          0: beat.item_key = KeyW'($urandom);
          1: beat.item_key = KeyW'($urandom_range(7));
          2: beat.item_key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          default: beat.item_key = KeyW'($urandom_range(16'hFFFF, 16'hFFF0));
        endcase
        beat.item_payload = PayW'($urandom);
        drive_beat(beat, 1'b0, '0);
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
